// File: hw/rtl/padc_pkg.sv
// padc_pkg: shared types and constants for the projected area drag coefficient unit
// depends on nothing
`timescale 1ns / 1ps
package padc_pkg;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [15:0] flow_x;
      logic signed [15:0] flow_y;
      logic signed [15:0] flow_z;
      logic [31:0]        surface_area;
      logic signed [15:0] surface_drag_coeff;
      logic signed [15:0] specularity;
      logic signed [15:0] accommodation;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [39:0] projected_area;
      logic [15:0] effective_drag_coeff;
   } rsp_type;

   localparam logic [1:0] CSR_USE_MODEL   = 2'd0;
   localparam logic [1:0] CSR_REF_AREA    = 2'd1;
   localparam logic [1:0] CSR_DEFAULT_CD  = 2'd2;
   localparam logic [1:0] CSR_RESERVED    = 2'd3;

   localparam int MAX_SURFACES = 256;

   localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
   localparam logic [15:0] COEF_015_Q16 = 16'd9830;
   localparam logic [15:0] DEFAULT_CD_RESET = 16'd9011;
   localparam int DIV_STEPS = 64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DOT1,
      ST_DOT2,
      ST_DOT3,
      ST_PROJ,
      ST_T1,
      ST_T2,
      ST_MOD,
      ST_COEFF,
      ST_CONTRIB,
      ST_ACC,
      ST_DIV,
      ST_OUT
   } state_type;

   // datapath command set, one bit per command; ST_ACC can raise acc and div_start together
   typedef struct packed {
      logic load;
      logic dot1;
      logic dot2;
      logic dot3;
      logic proj;
      logic t1;
      logic t2;
      logic modf;
      logic coeff;
      logic contrib;
      logic acc;
      logic div_start;
      logic div_step;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic div_done;
   } status_type;

endpackage

// File: hw/rtl/projected_area_drag_coeff_unit.sv
// projected_area_drag_coeff_unit: top level, register file plus controller and datapath
// depends on padc_pkg, padc_ctrl, padc_datapath
`timescale 1ns / 1ps
// usage:
//   req_ carries one surface per transfer; the transfer flagged last closes the set.
//   rsp_ carries one result per set: total projected area and weighted coefficient.
//   csr_ writes registers: 0 model enable, 1 reference_area, 2 default_drag_coeff;
//   other indexes are ignored. write only while the unit is idle.
// sequence:
//   each surface is worked through dot product, projection, modifier terms,
//   coefficient, contribution and accumulation, then the unit returns to idle with
//   req_ready high; no new surface is taken before it is back in idle.
//   the last surface then runs a restoring division, one quotient bit per cycle,
//   and rsp_valid rises once the division is done.
// reset:
//   synchronous, clears accumulators and registers to 1, 0, 9011.
// stalls:
//   a result holds in rsp_ until taken; no new surface is taken meanwhile.
module projected_area_drag_coeff_unit
   import padc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic        use_model_ff;
   logic [31:0] ref_area_ff;
   logic [15:0] default_cd_ff;
   cmd_type     cmd;
   status_type  status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_model_ff  <= 1'b1;
         ref_area_ff   <= '0;
         default_cd_ff <= DEFAULT_CD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_USE_MODEL:  use_model_ff  <= csr_data[0];
            CSR_REF_AREA:   ref_area_ff   <= csr_data;
            CSR_DEFAULT_CD: default_cd_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   padc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .use_model(use_model_ff), .status(status), .cmd(cmd)
   );

   padc_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_data(req_data),
      .use_model(use_model_ff), .ref_area(ref_area_ff), .default_cd(default_cd_ff),
      .status(status), .rsp_result(rsp_data)
   );

endmodule

// File: hw/rtl/padc_datapath.sv
// padc_datapath: multipliers (one shared by the three dot-product steps), accumulators and restoring divider
// depends on padc_pkg
`timescale 1ns / 1ps
module padc_datapath
   import padc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  req_type     req_data,
   input  logic        use_model,
   input  logic [31:0] ref_area,
   input  logic [15:0] default_cd,
   output status_type  status,
   output rsp_type     rsp_result
);

   req_type            item_ff;
   logic signed [34:0] dot_ff;
   logic [33:0]        proj_ff;
   logic [30:0]        inc_ff;
   logic [31:0]        t1_ff;
   logic [31:0]        term2_ff;
   logic [31:0]        mod_ff;
   logic [16:0]        coeff_ff;
   logic [50:0]        contrib_ff;
   logic [47:0]        area_sum_ff;
   logic [63:0]        wsum_ff;
   logic [63:0]        rem_ff;
   logic [63:0]        quo_ff;
   logic [6:0]         div_cnt_ff;
   logic [15:0]        cd_sel;

   logic signed [31:0] prod_s;
   logic signed [15:0] ma, mb;
   logic [14:0]        spec_c, accom_c;
   logic [33:0]        cpos;
   logic [65:0]        area_prod;
   logic [46:0]        t_prod;
   logic [47:0]        m2_prod;
   logic [48:0]        coeff_prod;
   logic [50:0]        contrib_prod;
   logic [48:0]        area_add;
   logic [64:0]        wsum_add;
   logic [63:0]        wsum_in;
   logic [64:0]        rem_shift;
   logic [64:0]        rem_sub;

   function automatic logic [14:0] clamp_frac(input logic signed [15:0] v);
      clamp_frac = v[15] ? 15'd0 : v[14:0];
   endfunction

   always_comb begin
      priority if (cmd.dot2) begin
         ma = item_ff.normal_y; mb = item_ff.flow_y;
      end else if (cmd.dot3) begin
         ma = item_ff.normal_z; mb = item_ff.flow_z;
      end else begin
         ma = item_ff.normal_x; mb = item_ff.flow_x;
      end
   end
   assign prod_s  = ma * mb;
   assign spec_c  = clamp_frac(item_ff.specularity);
   assign accom_c = clamp_frac(item_ff.accommodation);
   assign cpos    = dot_ff[34] ? 34'd0 : dot_ff[33:0];
   assign area_prod = {34'd0, item_ff.surface_area} * {32'd0, cpos};
   assign t_prod  = cmd.t1 ? {32'd0, accom_c} * {15'd0, ONE_Q30 + {1'b0, inc_ff}}
                           : {32'd0, spec_c} * {15'd0, ONE_Q30 - {1'b0, inc_ff}};
   assign m2_prod = {16'd0, t1_ff} * {32'd0, COEF_015_Q16};
   assign coeff_prod = {33'd0, (item_ff.surface_drag_coeff > 16'sd0) ?
                        item_ff.surface_drag_coeff : default_cd} * {17'd0, mod_ff};
   assign contrib_prod = {34'd0, coeff_ff} * {17'd0, proj_ff};
   assign area_add = {1'b0, area_sum_ff} + {15'd0, proj_ff};
   assign wsum_add = {1'b0, wsum_ff} + {14'd0, contrib_ff};
   assign wsum_in  = wsum_add[64] ? '1 : wsum_add[63:0];
   assign rem_shift = {rem_ff, quo_ff[63]};
   assign rem_sub   = rem_shift - {17'd0, area_sum_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;
      if (cmd.dot1) dot_ff <= -35'(prod_s);
      if (cmd.dot2 || cmd.dot3) dot_ff <= dot_ff - 35'(prod_s);
      if (cmd.proj) begin
         proj_ff <= area_prod[63:30];
         inc_ff  <= dot_ff[34] ? 31'd0 :
                    ((dot_ff[33:0] > {3'd0, ONE_Q30[30:0]}) ? {1'b1, 30'd0} : dot_ff[30:0]);
      end
      if (cmd.t1) term2_ff <= {2'd0, t_prod[46:17]};
      if (cmd.t2) t1_ff <= t_prod[46:15];
      if (cmd.modf) mod_ff <= ONE_Q30 + term2_ff - m2_prod[47:16];
      if (cmd.coeff) coeff_ff <= coeff_prod[46:30];
      if (cmd.contrib) contrib_ff <= contrib_prod;
      if (cmd.div_start) begin
         rem_ff <= 64'd0;
         quo_ff <= cmd.acc ? wsum_in : wsum_ff;
      end
      if (cmd.div_step) begin
         if (!rem_sub[64]) begin
            rem_ff <= rem_sub[63:0];
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[63:0];
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end
   end

   // term1 lives in term2_ff and t2 writes term2 into t1_ff; modifier built from both
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         area_sum_ff <= '0;
         wsum_ff     <= '0;
      end else if (cmd.acc) begin
         area_sum_ff <= area_add[48] ? '1 : area_add[47:0];
         wsum_ff     <= wsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.div_start) div_cnt_ff <= '0;
      else if (cmd.div_step) div_cnt_ff <= div_cnt_ff + 7'd1;
   end

   always_comb begin
      if (area_sum_ff == 48'd0) cd_sel = default_cd;
      else if (quo_ff[63:16] != 48'd0) cd_sel = 16'hFFFF;
      else cd_sel = quo_ff[15:0];
   end

   assign status.last     = item_ff.last;
   assign status.div_done = (div_cnt_ff == 7'(DIV_STEPS));

   always_comb begin
      if (!use_model) begin
         rsp_result.projected_area       = {8'd0, ref_area};
         rsp_result.effective_drag_coeff = default_cd;
      end else begin
         rsp_result.projected_area = (area_sum_ff[47:40] != 8'd0) ? '1 : area_sum_ff[39:0];
         rsp_result.effective_drag_coeff = cd_sel;
      end
   end

endmodule

// File: hw/rtl/padc_ctrl.sv
// padc_ctrl: sequencer for one surface and the end-of-set divide
// depends on padc_pkg
`timescale 1ns / 1ps
module padc_ctrl
   import padc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       use_model,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DOT1;
            end
         end
         ST_DOT1: begin
            cmd.dot1 = 1'b1;
            state_in = ST_DOT2;
         end
         ST_DOT2: begin
            cmd.dot2 = 1'b1;
            state_in = ST_DOT3;
         end
         ST_DOT3: begin
            cmd.dot3 = 1'b1;
            state_in = ST_PROJ;
         end
         ST_PROJ: begin
            cmd.proj = 1'b1;
            state_in = ST_T1;
         end
         ST_T1: begin
            cmd.t1 = 1'b1;
            state_in = ST_T2;
         end
         ST_T2: begin
            cmd.t2 = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            cmd.modf = 1'b1;
            state_in = ST_COEFF;
         end
         ST_COEFF: begin
            cmd.coeff = 1'b1;
            state_in = ST_CONTRIB;
         end
         ST_CONTRIB: begin
            cmd.contrib = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc       = use_model;
            cmd.div_start = status.last;
            state_in      = status.last ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_OUT;
            else cmd.div_step = 1'b1;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: hw/rtl/padc_checker.sv
// padc_port_checks: port-level assertions for the drag coefficient unit
// depends on padc_pkg, bound to projected_area_drag_coeff_unit
`timescale 1ns / 1ps
module padc_port_checks
   import padc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while result pending");

   a_not_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready)
      else $error("unit idle right after a transfer");

   a_idle_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind projected_area_drag_coeff_unit padc_port_checks u_padc_port_checks (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

// File: verif/padc_checker.sv
// padc_checker: watches the req, rsp and csr transfers of the drag coefficient unit,
// predicts each set result and compares it field by field; depends on padc_pkg
`timescale 1ns / 1ps
module padc_checker
   import padc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending_sets,
   output int          sets_seen
);

   rsp_type     set_results_q[$];
   logic        model_on;
   logic [31:0] ref_area;
   logic [15:0] dflt_cd;
   logic [47:0] area_acc;
   logic [63:0] weighted_acc;

   function automatic logic [15:0] clamp_frac(logic signed [15:0] v);
      return v < 0 ? 16'd0 : v;
   endfunction

   task automatic absorb_surface(input req_type s);
      logic signed [63:0] c;
      logic [63:0] cpos, proj, base, inc, t1, t2, modifier, coeff, contrib;
      logic [127:0] wide;
      logic [64:0] wsum;
      logic [48:0] asum;
      c = -($signed(s.normal_x) * $signed(s.flow_x) + $signed(s.normal_y) * $signed(s.flow_y)
            + $signed(s.normal_z) * $signed(s.flow_z));
      cpos = c > 0 ? c : 64'd0;
      proj = (64'(s.surface_area) * cpos) >> 30;
      base = s.surface_drag_coeff > 0 ? 64'(s.surface_drag_coeff) : 64'(dflt_cd);
      inc = c < 0 ? 64'd0 : (c > 64'sd1073741824 ? 64'd1073741824 : c);
      t1 = (64'(clamp_frac(s.accommodation)) * (64'd1073741824 + inc)) >> 15;
      t2 = (64'(clamp_frac(s.specularity)) * (64'd1073741824 - inc)) >> 15;
      modifier = 64'd1073741824 + (t1 >> 2) - ((t2 * 64'd9830) >> 16);
      coeff = (base * modifier) >> 30;
      wide = 128'(coeff) * 128'(proj);
      contrib = wide[63:0];
      asum = 49'(area_acc) + 49'(proj);
      area_acc = (asum > 49'hFFFF_FFFF_FFFF || proj[63:48] != 0) ? 48'hFFFF_FFFF_FFFF
                                                                 : asum[47:0];
      wsum = 65'(weighted_acc) + 65'(contrib);
      weighted_acc = wsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : wsum[63:0];
   endtask

   task automatic close_set(output rsp_type r);
      logic [63:0] q;
      if (!model_on) begin
         r.projected_area = 40'(ref_area);
         r.effective_drag_coeff = dflt_cd;
      end else begin
         r.effective_drag_coeff = dflt_cd;
         if (area_acc != 0) begin
            q = weighted_acc / 64'(area_acc);
            r.effective_drag_coeff = q > 64'hFFFF ? 16'hFFFF : q[15:0];
         end
         r.projected_area = area_acc > 48'hFF_FFFF_FFFF ? 40'hFF_FFFF_FFFF : area_acc[39:0];
      end
      area_acc = '0;
      weighted_acc = '0;
   endtask

   always @(posedge clock) begin
      rsp_type r, want;
      int errs;
      errs = 0;
      if (reset) begin
         model_on <= 1'b1;
         ref_area <= '0;
         dflt_cd <= DEFAULT_CD_RESET;
         area_acc = '0;
         weighted_acc = '0;
         set_results_q.delete();
         fail_count <= 0;
         sets_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_USE_MODEL:  model_on <= csr_data[0];
               CSR_REF_AREA:   ref_area <= csr_data;
               CSR_DEFAULT_CD: dflt_cd <= csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (model_on) absorb_surface(req_data);
            if (req_data.last) begin
               close_set(r);
               set_results_q.push_back(r);
            end
         end
         if (rsp_valid && rsp_ready) begin
            sets_seen <= sets_seen + 1;
            if (set_results_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               errs++;
            end else begin
               want = set_results_q.pop_front();
               if (want.projected_area !== rsp_data.projected_area) begin
                  $display("%0t: projected_area expected %h actual %h", $time,
                           want.projected_area, rsp_data.projected_area);
                  errs++;
               end
               if (want.effective_drag_coeff !== rsp_data.effective_drag_coeff) begin
                  $display("%0t: effective_drag_coeff expected %h actual %h", $time,
                           want.effective_drag_coeff, rsp_data.effective_drag_coeff);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      pending_sets <= set_results_q.size();
   end

endmodule

// File: verif/projected_area_drag_coeff_unit_test.sv
// projected_area_drag_coeff_unit_test: stimulus, register phases and verdict
// depends on padc_pkg, padc_checker, projected_area_drag_coeff_unit
`timescale 1ns / 1ps
module projected_area_drag_coeff_unit_test;
   import padc_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 100;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0, req_ready;
   req_type     req_data = '0;
   logic        rsp_valid, rsp_ready = 0;
   rsp_type     rsp_data;
   logic        csr_valid = 0, csr_ready;
   logic [1:0]  csr_index = CSR_USE_MODEL;
   logic [31:0] csr_data = 0;
   int          fail_count, pending_sets, sets_seen;
   int          idle_cycles = 0, surfaces_sent = 0;
   int          stall_mode = 0;

   always #5 clock = ~clock;

   projected_area_drag_coeff_unit i_dut (.*);

   padc_checker i_checker (.*);

   // receiver stall pattern, switching between modes
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 9) == 0);
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("FAIL projected_area_drag_coeff_unit");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain;
      while (pending_sets != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_surface(input req_type s);
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
      surfaces_sent++;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick16;
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type rand_surface(input bit is_last);
      req_type s;
      logic signed [15:0] v;
      int k;
      k = $urandom_range(0, 2);
      s.normal_x = k == 0 ? 16'sh7FFF : ($urandom_range(0, 3) == 0 ? pick16() : 16'sd0);
      s.normal_y = k == 1 ? 16'sh8000 : ($urandom_range(0, 3) == 0 ? pick16() : 16'sd0);
      s.normal_z = k == 2 ? 16'sh7FFF : ($urandom_range(0, 3) == 0 ? pick16() : 16'sd0);
      v = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
      s.flow_x = $urandom_range(0, 1) ? -$signed(s.normal_x) + $signed(16'($urandom_range(0, 4000)))
                                      : pick16();
      s.flow_y = $urandom_range(0, 1) ? v : pick16();
      s.flow_z = pick16();
      case ($urandom_range(0, 4))
         0: s.surface_area = 32'hFFFF_FFFF;
         1: s.surface_area = 0;
         default: s.surface_area = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h000F_FFFF);
      endcase
      s.surface_drag_coeff = pick16();
      s.specularity = pick16();
      s.accommodation = pick16();
      s.last = is_last;
      return s;
   endfunction

   task automatic send_set(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(posedge clock);
         send_surface(rand_surface(i == n - 1));
      end
   endtask

   task automatic random_phase(input int total);
      int target;
      target = surfaces_sent + total;
      while (surfaces_sent < target) begin
         send_set($urandom_range(1, 6));
         if ($urandom_range(0, 40) == 0) drain;
      end
   endtask

   initial begin
      req_type s;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed sets at the default settings
      s = '0;
      s.normal_x = 16'sh7FFF; s.flow_x = 16'sh8000; s.surface_area = 32'h0001_0000;
      s.surface_drag_coeff = 16'sh2000; s.last = 1;
      send_surface(s);
      s.specularity = 16'sh7FFF; s.accommodation = 16'sh7FFF;
      send_surface(s);
      s.specularity = 16'sh8000; s.accommodation = 16'sh8000; s.surface_drag_coeff = 16'sh8000;
      send_surface(s);
      s.flow_x = 16'sh7FFF; send_surface(s);
      s.normal_x = 16'sh8000; s.normal_y = 16'sh8000; s.normal_z = 16'sh8000;
      s.flow_x = 16'sh8000; s.flow_y = 16'sh8000; s.flow_z = 16'sh8000;
      s.surface_area = 32'hFFFF_FFFF; s.surface_drag_coeff = 16'sh7FFF;
      s.last = 0;
      repeat (40) send_surface(s);
      s.last = 1; send_surface(s);
      s = '0; s.normal_z = 16'sh4000; s.flow_z = 16'shE000; s.surface_area = 32'h0003_8000;
      s.specularity = 16'sh4000; s.accommodation = 16'sh2000;
      send_surface(s);
      s.last = 1; s.surface_drag_coeff = 16'sh1800; send_surface(s);
      drain;

      random_phase(500);
      drain;

      write_reg(CSR_DEFAULT_CD, 32'hFFFF);
      write_reg(CSR_REF_AREA, 32'hFFFF_FFFF);
      write_reg(CSR_RESERVED, 32'h1234_5678);
      random_phase(300);
      drain;

      write_reg(CSR_USE_MODEL, 32'h0);
      random_phase(150);
      drain;

      write_reg(CSR_REF_AREA, 32'h0);
      write_reg(CSR_DEFAULT_CD, 32'h0);
      random_phase(100);
      drain;

      write_reg(CSR_USE_MODEL, 32'hFFFF_FFFF);
      random_phase(350);
      drain;

      write_reg(CSR_DEFAULT_CD, $urandom_range(1, 65534));
      write_reg(CSR_REF_AREA, $urandom);
      random_phase(400);
      drain;

      $display("sent %0d surfaces, checked %0d set results over six register settings",
               surfaces_sent, sets_seen);
      if (fail_count == 0) $display("PASS projected_area_drag_coeff_unit");
      else $display("FAIL projected_area_drag_coeff_unit");
      $finish;
   end

endmodule
